### hdl/qte_pkg.sv
// quaternion to euler angles: shared types, widths and the cordic arctangent table
// used by the interfaces, cells and top of the block; depends on nothing
package qte_pkg;

  // default configuration of the cordic chains
  localparam int CordicStepsDef = 16;
  localparam int AngleBitsDef   = 16;
  localparam int TableLen       = 24;

  // datapath widths
  localparam int QW     = 16;   // quaternion component, Q2.14
  localparam int PW     = 32;   // product of two components
  localparam int SUM_W  = 34;   // doubled sums of products
  localparam int SARG_W = 30;   // clamped pitch argument, Q28 signed
  localparam int SMAG_W = 29;   // magnitude of the pitch argument
  localparam int RAD_W  = 57;   // 1 - s^2, 56 fractional bits
  localparam int ROOT_W = 29;   // floor square root, 28 fractional bits
  localparam int OPW    = 38;   // cordic x/y registers, room for gain and prerotation
  localparam int OUT_W  = 16;   // binary angle on the output

  localparam logic signed [SUM_W-1:0] OneQ28    = SUM_W'(64'sd268435456);
  localparam logic signed [SUM_W-1:0] NegOneQ28 = -SUM_W'(64'sd268435456);
  localparam logic [RAD_W-1:0]        OneQ56    = RAD_W'(1) << 56;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  function automatic logic [31:0] atan_turn32(input int i);
    logic [31:0] t;
    case (i % TableLen)
      0: t = 32'd536870912;   1: t = 32'd316933406;   2: t = 32'd167458907;
      3: t = 32'd85004756;    4: t = 32'd42667331;    5: t = 32'd21354465;
      6: t = 32'd10679838;    7: t = 32'd5340245;     8: t = 32'd2670163;
      9: t = 32'd1335087;     10: t = 32'd667544;     11: t = 32'd333772;
      12: t = 32'd166886;     13: t = 32'd83443;      14: t = 32'd41722;
      15: t = 32'd20861;      16: t = 32'd10430;      17: t = 32'd5215;
      18: t = 32'd2608;       19: t = 32'd1304;       20: t = 32'd652;
      21: t = 32'd326;        22: t = 32'd163;        23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // table entry rescaled to a full circle of 2^ab units, round half up
  function automatic logic [32:0] atan_entry(input int i, input int ab);
    logic [32:0] t;
    int          sh;
    sh = 32 - ab;
    t  = {1'b0, atan_turn32(i)} + (33'd1 << (sh - 1));
    return t >> sh;
  endfunction

  // operands that ride alongside the square root chain
  typedef struct packed {
    logic signed [SUM_W-1:0]  roll_y;
    logic signed [SUM_W-1:0]  roll_x;
    logic signed [SUM_W-1:0]  yaw_y;
    logic signed [SUM_W-1:0]  yaw_x;
    logic signed [SARG_W-1:0] s;
  } side_t;

endpackage

### hdl/qte_in_if.sv
// input channel of the quaternion to euler block: one quaternion per item
// depends on qte_pkg
interface qte_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [qte_pkg::QW-1:0]     quat_w;
  logic signed [qte_pkg::QW-1:0]     quat_x;
  logic signed [qte_pkg::QW-1:0]     quat_y;
  logic signed [qte_pkg::QW-1:0]     quat_z;

  modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### hdl/qte_out_if.sv
// output channel of the quaternion to euler block: roll, pitch and yaw per item
// depends on qte_pkg
interface qte_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qte_pkg::OUT_W-1:0]    roll_angle;
  logic signed [qte_pkg::OUT_W-1:0]    pitch_angle;
  logic signed [qte_pkg::OUT_W-1:0]    yaw_angle;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

### hdl/qte_sqrt_cell.sv
// one cell of the bit-serial square root chain: decides one root bit per cycle while en_i is high
// depends on qte_pkg
module qte_sqrt_cell #(
  parameter int K = 0
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [qte_pkg::RAD_W-1:0]     rem_i,
  input  logic [qte_pkg::ROOT_W-1:0]    root_i,
  output logic [qte_pkg::RAD_W-1:0]     rem_o,
  output logic [qte_pkg::ROOT_W-1:0]    root_o
);
  localparam int CW = qte_pkg::RAD_W + 3;

  logic [CW-1:0]                  trial;
  logic                           take;
  logic [qte_pkg::RAD_W-1:0]      rem_d;
  logic [qte_pkg::ROOT_W-1:0]     root_d;
  logic [qte_pkg::RAD_W-1:0]      rem_q;
  logic [qte_pkg::ROOT_W-1:0]     root_q;

  // trial subtrahend (2*root + 2^k) * 2^k, root holds only bits above k
  always_comb begin
    trial  = (CW'(root_i) << (K + 1)) | (CW'(1) << (2 * K));
    take   = CW'(rem_i) >= trial;
    rem_d  = take ? qte_pkg::RAD_W'(CW'(rem_i) - trial) : rem_i;
    root_d = take ? (root_i | (qte_pkg::ROOT_W'(1) << K)) : root_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
endmodule

### hdl/qte_cordic_pre.sv
// cordic entry cell: folds the left half plane into the right one by a quarter turn
// depends on qte_pkg
module qte_cordic_pre #(
  parameter int ANGLE_BITS = qte_pkg::AngleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [qte_pkg::OPW-1:0]    x_i,
  input  logic signed [qte_pkg::OPW-1:0]    y_i,
  output logic signed [qte_pkg::OPW-1:0]    x_o,
  output logic signed [qte_pkg::OPW-1:0]    y_o,
  output logic signed [ANGLE_BITS+1:0]      z_o,
  output logic                              zero_o
);
  localparam int ZW = ANGLE_BITS + 2;
  localparam logic signed [ZW-1:0] Quarter = ZW'(1) << (ANGLE_BITS - 2);

  logic signed [qte_pkg::OPW-1:0] x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]           z_d, z_q;
  logic                           zero_q;

  // quarter turn rotation when x is negative
  always_comb begin
    x_d = x_i;
    y_d = y_i;
    z_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_d = y_i;
        y_d = -x_i;
        z_d = Quarter;
      end else begin
        x_d = -y_i;
        y_d = x_i;
        z_d = -Quarter;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= (x_i == 0) && (y_i == 0);
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign zero_o = zero_q;
endmodule

### hdl/qte_cordic_cell.sv
// one vectoring cordic iteration: rotates toward the x axis and books the angle
// depends on qte_pkg
module qte_cordic_cell #(
  parameter int I          = 0,
  parameter int ANGLE_BITS = qte_pkg::AngleBitsDef
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [qte_pkg::OPW-1:0]    x_i,
  input  logic signed [qte_pkg::OPW-1:0]    y_i,
  input  logic signed [ANGLE_BITS+1:0]      z_i,
  input  logic                              zero_i,
  output logic signed [qte_pkg::OPW-1:0]    x_o,
  output logic signed [qte_pkg::OPW-1:0]    y_o,
  output logic signed [ANGLE_BITS+1:0]      z_o,
  output logic                              zero_o
);
  localparam int ZW = ANGLE_BITS + 2;
  localparam logic signed [ZW-1:0] Atan = ZW'(qte_pkg::atan_entry(I, ANGLE_BITS));

  logic signed [qte_pkg::OPW-1:0] dx, dy, x_q, y_q;
  logic signed [ZW-1:0]           z_q;
  logic                           zero_q;

  assign dx = y_i >>> I;
  assign dy = x_i >>> I;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (y_i >= 0) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + Atan;
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - Atan;
      end
      zero_q <= zero_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign zero_o = zero_q;
endmodule

### hdl/quaternion_to_euler_angles.sv
// Quaternion to Euler angles (roll, pitch, yaw, ZYX order).
//
// Channels: in_i takes one quaternion (w, x, y, z, signed Q2.14) per item;
// out_o gives roll, pitch and yaw as 16-bit binary angles (32768 = pi).
// Both use valid/ready; an item moves on an edge where both are high.
// Pipeline: three stages of products, sums and s^2, 29 square root cells
// (one root bit each), one quadrant cell, CORDIC_STEPS cordic cells and
// the output register.
// Throughput: one item per cycle while out_o is not stalled; every cell
// hands its item to the next cell each enabled cycle, and roll, yaw and
// pitch run in three parallel chains.
// A stalled receiver freezes the whole chain while out_o holds its item;
// in_i.ready is low exactly then. Items still enter while a result waits
// as long as the receiver takes it in the same cycle.
// Reset clears the valid marks in every stage and of the output register;
// no item is in flight afterwards. The block keeps no state between items.
// Depends on qte_pkg, qte_in_if, qte_out_if and the cell modules.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STEPS = qte_pkg::CordicStepsDef,
  parameter int ANGLE_BITS   = qte_pkg::AngleBitsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  qte_in_if.sink    in_i,
  qte_out_if.source out_o
);
  localparam int ZW    = ANGLE_BITS + 2;
  localparam int CW    = ZW + 16;
  localparam int NSQ   = qte_pkg::ROOT_W;
  localparam int NPIPE = 3 + NSQ + 1 + CORDIC_STEPS;
  localparam int ShR   = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int ShL   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic signed [CW-1:0] Rnd    = CW'((64'sd1 << ShR) >>> 1);
  localparam logic signed [CW-1:0] PosLim = CW'(64'sd16384);
  localparam logic signed [CW-1:0] NegLim = -CW'(64'sd16384);

  localparam int SW = qte_pkg::SUM_W;
  localparam int PW = qte_pkg::PW;

  logic en;
  logic in_fire;
  logic [NPIPE-1:0] valid_q;
  logic             out_valid_q;

  // whole chain advances unless the output item is stuck
  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign in_fire    = in_i.valid && en;

  // valid marks follow the items through the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[NPIPE-2:0], in_fire};
      out_valid_q <= valid_q[NPIPE-1];
    end
  end

  // stage 1: component products
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, wx_q, wy_q, wz_q, xy_q, xz_q, yz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= in_i.quat_w * in_i.quat_w;
      xx_q <= in_i.quat_x * in_i.quat_x;
      yy_q <= in_i.quat_y * in_i.quat_y;
      zz_q <= in_i.quat_z * in_i.quat_z;
      wx_q <= in_i.quat_w * in_i.quat_x;
      wy_q <= in_i.quat_w * in_i.quat_y;
      wz_q <= in_i.quat_w * in_i.quat_z;
      xy_q <= in_i.quat_x * in_i.quat_y;
      xz_q <= in_i.quat_x * in_i.quat_z;
      yz_q <= in_i.quat_y * in_i.quat_z;
    end
  end

  // stage 2: atan2 operands and the clamped pitch argument
  logic signed [SW-1:0] s_raw;
  logic signed [SW-1:0] s_clamp;
  qte_pkg::side_t       side2_q;
  always_comb begin
    s_raw = (SW'(wy_q) - SW'(xz_q)) <<< 1;
    if (s_raw > qte_pkg::OneQ28) begin
      s_clamp = qte_pkg::OneQ28;
    end else if (s_raw < qte_pkg::NegOneQ28) begin
      s_clamp = qte_pkg::NegOneQ28;
    end else begin
      s_clamp = s_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q.roll_y <= (SW'(yz_q) + SW'(wx_q)) <<< 1;
      side2_q.roll_x <= SW'(ww_q) - SW'(xx_q) - SW'(yy_q) + SW'(zz_q);
      side2_q.yaw_y  <= (SW'(xy_q) + SW'(wz_q)) <<< 1;
      side2_q.yaw_x  <= SW'(ww_q) + SW'(xx_q) - SW'(yy_q) - SW'(zz_q);
      side2_q.s      <= qte_pkg::SARG_W'(s_clamp);
    end
  end

  // stage 3: radicand 1 - s^2
  logic [qte_pkg::SMAG_W-1:0] s_mag;
  logic [2*qte_pkg::SMAG_W-1:0] s_sq;
  logic [qte_pkg::RAD_W-1:0]  rad_q;
  qte_pkg::side_t             side3_q;
  assign s_mag = side2_q.s[qte_pkg::SARG_W-1] ?
                 qte_pkg::SMAG_W'(-side2_q.s) : qte_pkg::SMAG_W'(side2_q.s);
  assign s_sq  = s_mag * s_mag;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q   <= qte_pkg::OneQ56 - qte_pkg::RAD_W'(s_sq);
      side3_q <= side2_q;
    end
  end

  // square root chain, most significant root bit first
  logic [qte_pkg::RAD_W-1:0]  rem_w  [NSQ+1];
  logic [qte_pkg::ROOT_W-1:0] root_w [NSQ+1];
  qte_pkg::side_t             side_q [NSQ];
  assign rem_w[0]  = rad_q;
  assign root_w[0] = '0;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    qte_sqrt_cell #(.K(NSQ - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_w[j]),
      .root_i (root_w[j]),
      .rem_o  (rem_w[j+1]),
      .root_o (root_w[j+1])
    );
  end

  // operands wait beside the root chain
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_q;
      for (int k = 1; k < NSQ; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // three cordic lanes: roll, pitch, yaw
  logic signed [qte_pkg::OPW-1:0] lane_x [3];
  logic signed [qte_pkg::OPW-1:0] lane_y [3];
  assign lane_x[0] = qte_pkg::OPW'(side_q[NSQ-1].roll_x);
  assign lane_y[0] = qte_pkg::OPW'(side_q[NSQ-1].roll_y);
  assign lane_x[1] = qte_pkg::OPW'({1'b0, root_w[NSQ]});
  assign lane_y[1] = qte_pkg::OPW'(side_q[NSQ-1].s);
  assign lane_x[2] = qte_pkg::OPW'(side_q[NSQ-1].yaw_x);
  assign lane_y[2] = qte_pkg::OPW'(side_q[NSQ-1].yaw_y);

  logic signed [qte_pkg::OPW-1:0] cx [3][CORDIC_STEPS+1];
  logic signed [qte_pkg::OPW-1:0] cy [3][CORDIC_STEPS+1];
  logic signed [ZW-1:0]           cz [3][CORDIC_STEPS+1];
  logic                           cn [3][CORDIC_STEPS+1];
  logic signed [CW-1:0]           full [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    qte_cordic_pre #(.ANGLE_BITS(ANGLE_BITS)) u_pre (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (lane_x[l]),
      .y_i    (lane_y[l]),
      .x_o    (cx[l][0]),
      .y_o    (cy[l][0]),
      .z_o    (cz[l][0]),
      .zero_o (cn[l][0])
    );
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      qte_cordic_cell #(.I(i), .ANGLE_BITS(ANGLE_BITS)) u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .x_i    (cx[l][i]),
        .y_i    (cy[l][i]),
        .z_i    (cz[l][i]),
        .zero_i (cn[l][i]),
        .x_o    (cx[l][i+1]),
        .y_o    (cy[l][i+1]),
        .z_o    (cz[l][i+1]),
        .zero_o (cn[l][i+1])
      );
    end
    // rescale to 16-bit binary angle, zero vector gives zero
    assign full[l] = cn[l][CORDIC_STEPS] ? '0 :
                     ((CW'(cz[l][CORDIC_STEPS]) + Rnd) >>> ShR) <<< ShL;
  end

  // pitch saturation to a quarter turn
  logic signed [CW-1:0] pitch_sat;
  always_comb begin
    if (full[1] > PosLim) begin
      pitch_sat = PosLim;
    end else if (full[1] < NegLim) begin
      pitch_sat = NegLim;
    end else begin
      pitch_sat = full[1];
    end
  end

  // output register
  logic signed [qte_pkg::OUT_W-1:0] roll_q, pitch_q, yaw_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= full[0][qte_pkg::OUT_W-1:0];
      pitch_q <= pitch_sat[qte_pkg::OUT_W-1:0];
      yaw_q   <= full[2][qte_pkg::OUT_W-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.roll_angle  = roll_q;
  assign out_o.pitch_angle = pitch_q;
  assign out_o.yaw_angle   = yaw_q;
endmodule

### hdl/qte_checker.sv
// port-level checks for quaternion_to_euler_angles and the bind that attaches them
// depends on quaternion_to_euler_angles and its channel interfaces
module qte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] roll_i,
  input logic [15:0] pitch_i,
  input logic [15:0] yaw_i
);
  // a waiting item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // a waiting item keeps its angles
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(roll_i) && $stable(pitch_i) && $stable(yaw_i))
    else $error("output item changed while stalled");

  // pitch of a valid item never leaves a quarter turn
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($signed(pitch_i) <= 16'sd16384) && ($signed(pitch_i) >= -16'sd16384))
    else $error("pitch beyond a quarter turn");

  // input side only blocks while an output item is stuck
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input blocked with free output");
endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .roll_i      (out_o.roll_angle),
  .pitch_i     (out_o.pitch_angle),
  .yaw_i       (out_o.yaw_angle)
);
